@@ hdl/tim_pkg.sv @@
// Shared types and constants for the timestamp interpolation matcher.
package tim_pkg;
	localparam int HistDepth = 16;
	localparam int HistIdxBits = 4;
	localparam int HistCntBits = 5;
	localparam int FixDepth = 8;
	localparam int FixIdxBits = 3;
	localparam int FixCntBits = 4;
	localparam int TimeBits = 48;
	localparam int MaxMatches = 8;
	localparam int MatchCntBits = 4;
	localparam int QuoBits = 64;
	localparam int DivSteps = 128;
	localparam int DivCntBits = 7;

	typedef enum logic {
		OP_POSITION = 1'b0,
		OP_FIX      = 1'b1
	} op_t;

	typedef struct packed {
		logic               operation;
		logic [47:0]        timestamp;
		logic signed [63:0] coord_x;
		logic signed [63:0] coord_y;
		logic signed [63:0] coord_z;
		logic signed [31:0] accuracy_x;
		logic signed [31:0] accuracy_y;
		logic signed [31:0] accuracy_z;
	} in_item_t;

	typedef struct packed {
		logic [47:0]        match_time;
		logic signed [63:0] rel_x;
		logic signed [63:0] rel_y;
		logic signed [63:0] rel_z;
		logic signed [63:0] global_x;
		logic signed [63:0] global_y;
		logic signed [63:0] global_z;
		logic signed [31:0] acc_out_x;
		logic signed [31:0] acc_out_y;
		logic signed [31:0] acc_out_z;
		logic               last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STORE,
		ST_CHECK,
		ST_SCAN,
		ST_DECIDE,
		ST_LOAD,
		ST_DIV,
		ST_EMIT,
		ST_TRIM,
		ST_CLOSE,
		ST_SHOW
	} state_t;

	// Decision about the head fix after a history scan.
	typedef enum logic [1:0] {
		DEC_WAIT,
		DEC_DISCARD,
		DEC_MATCH
	} decision_t;

	typedef struct packed {
		logic store;
		logic scan_start;
		logic scan_step;
		logic load;
		logic div_start;
		logic div_step;
		logic emit;
		logic pop;
		logic trim;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic      is_fix;
		logic      ready_to_match;
		logic      scan_done;
		decision_t decision;
		logic      div_done;
		logic      fixes_left;
		logic      hist_multi;
	} status_t;
endpackage

@@ hdl/timestamp_interp_matcher.sv @@
// Top level of the timestamp interpolation matcher.
// An item transfer happens when start is high and busy low; busy then stays high
// until every match caused by the item has been shown. Each match takes a history
// scan, the check, decide, load and emit states, and the shared serial unit: a
// start step, then for each of the three axes a 48-step shift-add multiply and a
// 128-step restoring divide. A match is held until the next one has been computed
// or matching stops, so it is shown during the emit of the following match, and
// the final match of an item is flagged last in the close state and shown in the
// show state after matching ends. An item causes up to eight matches.
// Results appear on result with result_valid high for one cycle and must be taken
// at once.
module timestamp_interp_matcher
	import tim_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      result_valid,
	output out_item_t result
);
	cmd_t cmd;
	status_t status;
	logic capture;

	tim_control u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.capture(capture), .cmd(cmd), .status(status), .strobe(result_valid)
	);
	tim_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .capture(capture),
		.cmd(cmd), .status(status), .result(result)
	);
endmodule

@@ hdl/tim_datapath.sv @@
// Datapath: history store, fix queue, scan and serial interpolation divider.
module tim_datapath
	import tim_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item,
	input  logic      capture,
	input  cmd_t      cmd,
	output status_t   status,
	output out_item_t result
);
	// Circular stores: head pointer plus count.
	logic [47:0] hist_t_q [HistDepth];
	logic [63:0] hist_x_q [HistDepth];
	logic [63:0] hist_y_q [HistDepth];
	logic [63:0] hist_z_q [HistDepth];
	logic [HistIdxBits-1:0] hhead_q;
	logic [HistCntBits-1:0] hcnt_q;

	logic [47:0] fix_t_q [FixDepth];
	logic [63:0] fix_gx_q [FixDepth];
	logic [63:0] fix_gy_q [FixDepth];
	logic [63:0] fix_gz_q [FixDepth];
	logic [31:0] fix_ax_q [FixDepth];
	logic [31:0] fix_ay_q [FixDepth];
	logic [31:0] fix_az_q [FixDepth];
	logic [FixIdxBits-1:0] fhead_q;
	logic [FixCntBits-1:0] fcnt_q;

	in_item_t item_q;
	logic [HistCntBits-1:0] p_q;
	logic [47:0] ft;
	logic [47:0] hp_t;
	logic [HistIdxBits-1:0] hp_idx, prv_idx, nxt_idx, prv_ofs;
	logic [HistCntBits-1:0] prv_pos;
	decision_t decision_c;
	logic scan_done_c;
	logic div_done_c;

	// Interpolation operands.
	logic [47:0] den_q;
	logic [47:0] num_q;
	logic [47:0] mul_sh_q;
	logic        mul_ph_q;
	logic [127:0] prod_q;
	logic [2:0] neg_q;
	logic [63:0] prev_q [3];
	logic [63:0] mag_q [3];
	logic [63:0] quo_q [3];
	logic [63:0] rem_q;
	logic [1:0] axis_q;
	logic [DivCntBits-1:0] dcnt_q;
	logic [47:0] num_c, den_c;
	logic [63:0] pv [3];
	logic [63:0] nx [3];

	assign ft = fix_t_q[fhead_q];
	assign hp_idx = hhead_q + p_q[HistIdxBits-1:0];
	assign hp_t = hist_t_q[hp_idx];

	always_ff @(posedge clk) begin
		if (capture) item_q <= item;
	end

	// Scan for the first history entry at or after the head fix time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
		end else if (cmd.scan_start) begin
			p_q <= '0;
		end else if (cmd.scan_step) begin
			p_q <= p_q + 1'b1;
		end
	end
	assign scan_done_c = (p_q == hcnt_q) || !(hp_t < ft);

	always_comb begin
		if (p_q == hcnt_q) decision_c = DEC_WAIT;
		else if (p_q != '0) decision_c = DEC_MATCH;
		else if (hist_t_q[hhead_q] == ft) decision_c = DEC_MATCH;
		else decision_c = DEC_DISCARD;
	end

	always_comb begin
		if (p_q != '0) prv_pos = p_q - 1'b1;
		else prv_pos = '0;
	end
	assign prv_ofs = prv_pos[HistIdxBits-1:0];
	assign prv_idx = hhead_q + prv_ofs;
	assign nxt_idx = prv_idx + 1'b1;

	always_comb begin
		num_c = ft - hist_t_q[prv_idx];
		den_c = hist_t_q[nxt_idx] - hist_t_q[prv_idx];
		if (den_c == '0) begin
			num_c = 48'd1;
			den_c = 48'd2;
		end
		pv[0] = hist_x_q[prv_idx];
		pv[1] = hist_y_q[prv_idx];
		pv[2] = hist_z_q[prv_idx];
		nx[0] = hist_x_q[nxt_idx];
		nx[1] = hist_y_q[nxt_idx];
		nx[2] = hist_z_q[nxt_idx];
	end

	logic [64:0] trial;
	logic [63:0] rem_sh;
	logic        rem_top;
	logic [63:0] mul_a;
	assign mul_a = mag_q[axis_q];
	assign rem_top = rem_q[63];
	assign rem_sh = {rem_q[62:0], prod_q[127]};
	assign trial = {rem_top, rem_sh} - {17'd0, den_q};

	// One shared unit, one axis after another: a shift-add multiply of the
	// magnitude by the numerator, then a restoring divide, one bit a cycle.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			den_q <= den_c;
			num_q <= num_c;
			for (int a = 0; a < 3; a++) begin
				neg_q[a] <= (pv[a] ^ 64'h8000_0000_0000_0000) >
					(nx[a] ^ 64'h8000_0000_0000_0000);
				mag_q[a] <= ((pv[a] ^ 64'h8000_0000_0000_0000) >
					(nx[a] ^ 64'h8000_0000_0000_0000)) ? pv[a] - nx[a] : nx[a] - pv[a];
				prev_q[a] <= pv[a];
			end
			axis_q <= '0;
		end else if (cmd.div_start) begin
			prod_q <= '0;
			rem_q <= '0;
			mul_sh_q <= num_q;
			mul_ph_q <= 1'b1;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (mul_ph_q) begin
				prod_q <= {prod_q[126:0], 1'b0} +
					(mul_sh_q[47] ? {64'd0, mul_a} : 128'd0);
				mul_sh_q <= {mul_sh_q[46:0], 1'b0};
				if (dcnt_q == DivCntBits'(TimeBits - 1)) begin
					mul_ph_q <= 1'b0;
					dcnt_q <= '0;
				end
			end else begin
				prod_q <= {prod_q[126:0], 1'b0};
				if (!trial[64]) rem_q <= trial[63:0];
				else rem_q <= rem_sh;
				quo_q[axis_q] <= {quo_q[axis_q][62:0], ~trial[64]};
				if (dcnt_q == DivCntBits'(DivSteps - 1) && axis_q != 2'd2) begin
					axis_q <= axis_q + 1'b1;
					prod_q <= '0;
					rem_q <= '0;
					mul_sh_q <= num_q;
					mul_ph_q <= 1'b1;
				end
			end
		end
	end
	assign div_done_c = cmd.div_step && !mul_ph_q &&
		dcnt_q == DivCntBits'(DivSteps - 1) && axis_q == 2'd2;

	// Store, emit, drop and trim updates of history and queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hhead_q <= '0;
			hcnt_q <= '0;
			fhead_q <= '0;
			fcnt_q <= '0;
		end else begin
			if (cmd.store) begin
				if (item_q.operation == OP_POSITION) begin
					if (hcnt_q == HistCntBits'(HistDepth)) hhead_q <= hhead_q + 1'b1;
					else hcnt_q <= hcnt_q + 1'b1;
				end else if (fcnt_q != FixCntBits'(FixDepth)) begin
					fcnt_q <= fcnt_q + 1'b1;
				end
			end else if (cmd.emit) begin
				hhead_q <= prv_idx;
				hcnt_q <= hcnt_q - {1'b0, prv_ofs};
				fhead_q <= fhead_q + 1'b1;
				fcnt_q <= fcnt_q - 1'b1;
			end else if (cmd.pop) begin
				fhead_q <= fhead_q + 1'b1;
				fcnt_q <= fcnt_q - 1'b1;
			end else if (cmd.trim) begin
				hhead_q <= hhead_q + HistIdxBits'(hcnt_q - 1'b1);
				hcnt_q <= HistCntBits'(1);
			end
		end
	end

	logic [HistIdxBits-1:0] wr_h;
	logic [FixIdxBits-1:0]  wr_f;
	assign wr_h = (hcnt_q == HistCntBits'(HistDepth)) ? hhead_q :
		hhead_q + hcnt_q[HistIdxBits-1:0];
	assign wr_f = fhead_q + fcnt_q[FixIdxBits-1:0];

	always_ff @(posedge clk) begin
		if (cmd.store && item_q.operation == OP_POSITION) begin
			hist_t_q[wr_h] <= item_q.timestamp;
			hist_x_q[wr_h] <= item_q.coord_x;
			hist_y_q[wr_h] <= item_q.coord_y;
			hist_z_q[wr_h] <= item_q.coord_z;
		end
		if (cmd.store && item_q.operation == OP_FIX && fcnt_q != FixCntBits'(FixDepth)) begin
			fix_t_q[wr_f] <= item_q.timestamp;
			fix_gx_q[wr_f] <= item_q.coord_x;
			fix_gy_q[wr_f] <= item_q.coord_y;
			fix_gz_q[wr_f] <= item_q.coord_z;
			fix_ax_q[wr_f] <= item_q.accuracy_x;
			fix_ay_q[wr_f] <= item_q.accuracy_y;
			fix_az_q[wr_f] <= item_q.accuracy_z;
		end
	end

	always_comb begin
		status.is_fix = item_q.operation;
		status.ready_to_match = fcnt_q != '0 && hcnt_q > HistCntBits'(1);
		status.scan_done = scan_done_c;
		status.decision = decision_c;
		status.div_done = div_done_c;
		status.fixes_left = fcnt_q != '0;
		status.hist_multi = hcnt_q > HistCntBits'(1);
	end

	// A match waits here until it is known whether another one follows it.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result.match_time <= ft;
			result.rel_x <= neg_q[0] ? prev_q[0] - quo_q[0] : prev_q[0] + quo_q[0];
			result.rel_y <= neg_q[1] ? prev_q[1] - quo_q[1] : prev_q[1] + quo_q[1];
			result.rel_z <= neg_q[2] ? prev_q[2] - quo_q[2] : prev_q[2] + quo_q[2];
			result.global_x <= fix_gx_q[fhead_q];
			result.global_y <= fix_gy_q[fhead_q];
			result.global_z <= fix_gz_q[fhead_q];
			result.acc_out_x <= fix_ax_q[fhead_q];
			result.acc_out_y <= fix_ay_q[fhead_q];
			result.acc_out_z <= fix_az_q[fhead_q];
			result.last <= 1'b0;
		end else if (cmd.last) begin
			result.last <= 1'b1;
		end
	end
endmodule

@@ hdl/tim_control.sv @@
// Controller state machine sequencing store, scan, divide and emit.
module tim_control
	import tim_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output logic    capture,
	output cmd_t    cmd,
	input  status_t status,
	output logic    strobe
);
	state_t state_q, state_d;
	logic [MatchCntBits-1:0] n_q;
	logic pend_q;
	logic div_started_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			pend_q <= 1'b0;
			div_started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			div_started_q <= state_q == ST_DIV;
			if (state_q == ST_STORE) n_q <= '0;
			else if (cmd.emit) n_q <= n_q + 1'b1;
			// A computed match stays pending until it has been shown.
			if (cmd.emit) pend_q <= 1'b1;
			else if (state_q == ST_SHOW) pend_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_STORE;
			ST_STORE:  state_d = ST_CHECK;
			ST_CHECK: begin
				if (!status.ready_to_match || n_q == MatchCntBits'(MaxMatches))
					state_d = pend_q ? ST_CLOSE : ST_IDLE;
				else state_d = ST_SCAN;
			end
			ST_SCAN:   if (status.scan_done) state_d = ST_DECIDE;
			ST_DECIDE: begin
				unique case (status.decision)
					DEC_MATCH:   state_d = ST_LOAD;
					DEC_DISCARD: state_d = ST_CHECK;
					DEC_WAIT:    state_d = ST_TRIM;
					default:     state_d = ST_TRIM;
				endcase
			end
			ST_LOAD:   state_d = ST_DIV;
			ST_DIV:    if (status.div_done) state_d = ST_EMIT;
			ST_EMIT:   state_d = ST_CHECK;
			ST_TRIM:   state_d = pend_q ? ST_CLOSE : ST_IDLE;
			ST_CLOSE:  state_d = ST_SHOW;
			ST_SHOW:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		capture = 1'b0;
		strobe = 1'b0;
		unique case (state_q)
			ST_IDLE:   capture = start;
			ST_STORE:  cmd.store = 1'b1;
			ST_CHECK:  cmd.scan_start = 1'b1;
			ST_SCAN:   cmd.scan_step = !status.scan_done;
			ST_DECIDE: cmd.pop = status.decision == DEC_DISCARD;
			ST_LOAD:   cmd.load = 1'b1;
			ST_DIV: begin
				cmd.div_start = !div_started_q;
				cmd.div_step = div_started_q;
			end
			ST_EMIT: begin
				// The previous match is shown while the new one is latched.
				cmd.emit = 1'b1;
				strobe = pend_q;
			end
			ST_TRIM:   cmd.trim = 1'b1;
			ST_CLOSE:  cmd.last = 1'b1;
			ST_SHOW:   strobe = 1'b1;
			default:   cmd = '0;
		endcase
	end

	assign busy = state_q != ST_IDLE;
endmodule

@@ hdl/tim_checker.sv @@
// Port-level checker for the matcher, bound to the top level.
module tim_checker
	import tim_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after transfer");
	a_valid_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result held two cycles");
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result while idle");
endmodule

bind timestamp_interp_matcher tim_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_valid(result_valid)
);
